[design/fcic_pkg.sv]
// shared types and constants of the fourth-order crossover iir core
package fcic_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int SAMPLE_BITS     = 24;
    localparam int CHAN_FIELD_BITS = 3;
    localparam int CH_BITS         = $clog2(MAX_CHANNELS);
    localparam int ENTRY_BITS      = CH_BITS + 1;
    localparam int ENTRIES         = 2 * MAX_CHANNELS;
    localparam int HIST_LEN        = 4;

    localparam int COEF_BITS    = 32;
    localparam int FRAC_BITS    = 28;
    // x0 + 4x1 + 6x2 + 4x3 + x4 spans sixteen times a sample
    localparam int TAP_BITS     = SAMPLE_BITS + 4;
    localparam int PROD_BITS    = COEF_BITS + TAP_BITS;
    localparam int ACC_BITS     = PROD_BITS + 1;
    localparam int Q_BITS       = ACC_BITS - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] MAC_LAST = 3'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOW_GAIN       = 3'd0,
        CFG_HIGH_GAIN      = 3'd1,
        CFG_FEEDBACK_ONE   = 3'd2,
        CFG_FEEDBACK_TWO   = 3'd3,
        CFG_FEEDBACK_THREE = 3'd4,
        CFG_FEEDBACK_FOUR  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DONE
    } state_t;

    // element 0 is the newest sample
    typedef logic [HIST_LEN-1:0][SAMPLE_BITS-1:0] hist_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic acc_sub;
    } mac_ctrl_t;

endpackage

[design/fcic_mac.sv]
// shared multiply-accumulate unit: registered product, then signed accumulate
module fcic_mac (
    input  logic                                     aclk,
    input  fcic_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [fcic_pkg::COEF_BITS-1:0]    mac_a,
    input  logic signed [fcic_pkg::TAP_BITS-1:0]     mac_b,
    output logic signed [fcic_pkg::ACC_BITS-1:0]     acc
);

    logic signed [fcic_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [fcic_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [fcic_pkg::ACC_BITS-1:0]  prod_ext;

    assign prod_ext = fcic_pkg::ACC_BITS'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mac_a * mac_b;
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= ctrl.acc_sub ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    assign acc = acc_reg;

endmodule

[design/fourth_order_crossover_iir_core.sv]
// top level of the multichannel fourth-order crossover iir core
// A word carries one signed sample, a channel and a band select (0 low-pass, 1 high-pass);
// each word gives exactly one filtered word back, with its channel and band echoed.
// Each channel and band keeps its own four input and four output samples in two
// 16-entry history memories, read once when the word is taken and written back
// when the result is handed over. One multiplier does all five products in turn, and a new
// word is taken only in idle, after the last result has been written back; a waiting result
// stalls the write-back and so holds off the next word. All history reads as zero after reset
// (per-entry valid flags), so there is no clearing sweep. Coefficient writes are meant for idle
// time only.
module fourth_order_crossover_iir_core (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // coefficient write port
    input  logic                                        cfg_we,
    input  logic [fcic_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [fcic_pkg::COEF_BITS-1:0]              cfg_data,
    // input words
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic                                        s_command,
    input  logic [fcic_pkg::CHAN_FIELD_BITS-1:0]        s_channel,
    input  logic signed [fcic_pkg::SAMPLE_BITS-1:0]     s_sample_in,
    // result words
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [fcic_pkg::SAMPLE_BITS-1:0]     m_sample_out,
    output logic [fcic_pkg::CHAN_FIELD_BITS-1:0]        m_channel_out,
    output logic                                        m_band_out
);

    localparam int SB = fcic_pkg::SAMPLE_BITS;
    localparam int TB = fcic_pkg::TAP_BITS;
    localparam int AB = fcic_pkg::ACC_BITS;
    localparam int QB = fcic_pkg::Q_BITS;
    localparam int FB = fcic_pkg::FRAC_BITS;

    // saturation limits, in the width of the rounded quotient
    localparam logic signed [QB-1:0] Q_MAX = QB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [QB-1:0] Q_MIN = QB'(-(64'sd1 <<< (SB - 1)));
    localparam logic signed [AB-1:0] RND_HALF = AB'(64'sd1 <<< (FB - 1));

    // coefficient registers
    logic signed [fcic_pkg::COEF_BITS-1:0] low_gain_reg, high_gain_reg;
    logic signed [fcic_pkg::COEF_BITS-1:0] fb_one_reg, fb_two_reg, fb_three_reg, fb_four_reg;

    // sequencer
    fcic_pkg::state_t state_reg, state_next;
    logic [fcic_pkg::STEP_BITS-1:0] k_reg;
    fcic_pkg::mac_ctrl_t mac_ctrl;
    logic accept;
    logic commit;

    // the word at work
    logic                                  band_reg;
    logic [fcic_pkg::CHAN_FIELD_BITS-1:0]  chan_reg;
    logic signed [SB-1:0]                  x0_reg;
    logic [fcic_pkg::ENTRY_BITS-1:0]       entry_reg;
    logic [fcic_pkg::ENTRY_BITS-1:0]       rd_entry;
    logic                                  hit_reg;

    // history memories and their valid flags
    fcic_pkg::hist_t xmem [fcic_pkg::ENTRIES];
    fcic_pkg::hist_t ymem [fcic_pkg::ENTRIES];
    fcic_pkg::hist_t xrd_reg, yrd_reg;
    fcic_pkg::hist_t xh_reg, yh_reg;
    fcic_pkg::hist_t xh_c, yh_c;
    logic [fcic_pkg::ENTRIES-1:0] hist_valid_reg;

    // datapath
    logic signed [TB-1:0] taps_reg, taps_c;
    logic signed [TB-1:0] e0, e1, e2, e3, e4, outer;
    logic signed [fcic_pkg::COEF_BITS-1:0] mac_a;
    logic signed [TB-1:0] mac_b;
    logic signed [AB-1:0] acc;
    logic signed [AB-1:0] acc_rnd;
    logic signed [QB-1:0] q;
    logic signed [SB-1:0] res;

    // output register
    logic                  m_valid_reg;
    logic signed [SB-1:0]  m_sample_reg;
    logic [fcic_pkg::CHAN_FIELD_BITS-1:0] m_chan_reg;
    logic                  m_band_reg;

    // coefficient writes; codes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_gain_reg  <= '0;
            high_gain_reg <= '0;
            fb_one_reg    <= '0;
            fb_two_reg    <= '0;
            fb_three_reg  <= '0;
            fb_four_reg   <= '0;
        end else if (cfg_we) begin
            case (fcic_pkg::cfg_idx_t'(cfg_index))
                fcic_pkg::CFG_LOW_GAIN:       low_gain_reg  <= signed'(cfg_data);
                fcic_pkg::CFG_HIGH_GAIN:      high_gain_reg <= signed'(cfg_data);
                fcic_pkg::CFG_FEEDBACK_ONE:   fb_one_reg    <= signed'(cfg_data);
                fcic_pkg::CFG_FEEDBACK_TWO:   fb_two_reg    <= signed'(cfg_data);
                fcic_pkg::CFG_FEEDBACK_THREE: fb_three_reg  <= signed'(cfg_data);
                fcic_pkg::CFG_FEEDBACK_FOUR:  fb_four_reg   <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcic_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        commit     = 1'b0;
        mac_ctrl   = '0;
        case (state_reg)
            fcic_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = fcic_pkg::ST_LOAD;
                end
            end
            fcic_pkg::ST_LOAD: begin
                mac_ctrl.clear = 1'b1;
                state_next     = fcic_pkg::ST_MAC;
            end
            fcic_pkg::ST_MAC: begin
                // step k multiplies operand k and adds the product of step k-1
                mac_ctrl.mul_en  = (k_reg < fcic_pkg::MAC_LAST);
                mac_ctrl.acc_en  = (k_reg != '0);
                mac_ctrl.acc_sub = (k_reg > 3'd1);
                if (k_reg == fcic_pkg::MAC_LAST) begin
                    state_next = fcic_pkg::ST_DONE;
                end
            end
            fcic_pkg::ST_DONE: begin
                // hand over only once the output register is free
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = fcic_pkg::ST_IDLE;
                end
            end
            default: state_next = fcic_pkg::ST_IDLE;
        endcase
    end

    assign accept = s_valid && s_ready;

    // history entry: channel folded onto the stored channels, band as low bit
    assign rd_entry = {s_channel[fcic_pkg::CH_BITS-1:0], s_command};

    // memory reads on acceptance, write-back on hand-over
    always_ff @(posedge aclk) begin
        if (accept) begin
            xrd_reg <= xmem[rd_entry];
            yrd_reg <= ymem[rd_entry];
        end
        if (commit) begin
            xmem[entry_reg] <= fcic_pkg::hist_t'({xh_reg[2:0], x0_reg});
            ymem[entry_reg] <= fcic_pkg::hist_t'({yh_reg[2:0], res});
        end
    end

    // valid flags: an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg <= '0;
        end else if (commit) begin
            hist_valid_reg[entry_reg] <= 1'b1;
        end
    end

    assign xh_c = hit_reg ? xrd_reg : '0;
    assign yh_c = hit_reg ? yrd_reg : '0;

    // numerator taps: 1,4,6,4,1 or 1,-4,6,-4,1
    assign e0    = TB'(x0_reg);
    assign e1    = TB'(signed'(xh_c[0]));
    assign e2    = TB'(signed'(xh_c[1]));
    assign e3    = TB'(signed'(xh_c[2]));
    assign e4    = TB'(signed'(xh_c[3]));
    assign outer = (e1 + e3) <<< 2;
    assign taps_c = band_reg ? (e0 + e4 + (e2 <<< 2) + (e2 <<< 1) - outer)
                             : (e0 + e4 + (e2 <<< 2) + (e2 <<< 1) + outer);

    // word capture, history latch and step counter
    always_ff @(posedge aclk) begin
        if (accept) begin
            band_reg  <= s_command;
            chan_reg  <= s_channel;
            x0_reg    <= s_sample_in;
            entry_reg <= rd_entry;
            hit_reg   <= hist_valid_reg[rd_entry];
        end
        if (state_reg == fcic_pkg::ST_LOAD) begin
            xh_reg   <= xh_c;
            yh_reg   <= yh_c;
            taps_reg <= taps_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (state_reg == fcic_pkg::ST_LOAD) begin
            k_reg <= '0;
        end else if (state_reg == fcic_pkg::ST_MAC) begin
            k_reg <= k_reg + 3'd1;
        end
    end

    // operand select: gain times taps, then feedback on the newest output first
    always_comb begin
        mac_a = '0;
        mac_b = '0;
        case (k_reg)
            3'd0: begin
                mac_a = band_reg ? high_gain_reg : low_gain_reg;
                mac_b = taps_reg;
            end
            3'd1: begin
                mac_a = fb_one_reg;
                mac_b = TB'(signed'(yh_reg[0]));
            end
            3'd2: begin
                mac_a = fb_two_reg;
                mac_b = TB'(signed'(yh_reg[1]));
            end
            3'd3: begin
                mac_a = fb_three_reg;
                mac_b = TB'(signed'(yh_reg[2]));
            end
            3'd4: begin
                mac_a = fb_four_reg;
                mac_b = TB'(signed'(yh_reg[3]));
            end
            default: ;
        endcase
    end

    fcic_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .mac_a (mac_a),
        .mac_b (mac_b),
        .acc   (acc)
    );

    // round half up, drop the fraction, saturate
    assign acc_rnd = acc + RND_HALF;
    assign q       = signed'(acc_rnd[AB-1:FB]);

    always_comb begin
        if (q > Q_MAX) begin
            res = SB'(Q_MAX);
        end else if (q < Q_MIN) begin
            res = SB'(Q_MIN);
        end else begin
            res = q[SB-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_sample_reg <= res;
            m_chan_reg   <= chan_reg;
            m_band_reg   <= band_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_channel_out = m_chan_reg;
    assign m_band_out    = m_band_reg;

    // a taken word always goes to the history load
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == fcic_pkg::ST_LOAD)
        else $error("accepted word did not start a history load");

    // a write-back always leaves a result waiting
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("write-back without a result word");

    // a fresh result only comes from the hand-over state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fcic_pkg::ST_DONE))
        else $error("result word appeared outside hand-over");

    // the step counter stays within the five products and the last add
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fcic_pkg::ST_MAC |-> k_reg <= fcic_pkg::MAC_LAST)
        else $error("mac step counter overran");

endmodule
